@@ design/dvrt_pkg.sv @@
// Shared constants and types for the distance-vector route table.
// Used by the table storage, the core sequencer and the port checker.
`timescale 1ns / 1ps
`default_nettype none

package dvrt_pkg;

    localparam int METRIC_W = 5;
    localparam int HOP_W    = 2;
    localparam int COUNT_W  = 6;

    localparam logic [METRIC_W-1:0] UNREACH   = 5'd16;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = 6'd63;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_SET   = 2'd0;
    localparam cmd_t CMD_ROUND = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;
    localparam cmd_t CMD_CLEAR = 2'd3;

endpackage

`default_nettype wire

@@ design/dvrt_table.sv @@
// Metric and next-hop storage: one write port, two registered read ports.
// Entries never written since reset or clear read as their reset values.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_table #(
    parameter int ROUTERS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          clear,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(ROUTERS)-1:0]    wr_row,
    input  wire logic [$clog2(ROUTERS)-1:0]    wr_col,
    input  wire logic [dvrt_pkg::METRIC_W-1:0] wr_metric,
    input  wire logic [$clog2(ROUTERS)-1:0]    wr_hop,
    input  wire logic [$clog2(ROUTERS)-1:0]    a_row,
    input  wire logic [$clog2(ROUTERS)-1:0]    a_col,
    input  wire logic [$clog2(ROUTERS)-1:0]    b_row,
    input  wire logic [$clog2(ROUTERS)-1:0]    b_col,
    output logic      [dvrt_pkg::METRIC_W-1:0] a_metric,
    output logic      [$clog2(ROUTERS)-1:0]    a_hop,
    output logic      [dvrt_pkg::METRIC_W-1:0] b_metric,
    output logic      [$clog2(ROUTERS)-1:0]    b_hop
);

    localparam int IW       = $clog2(ROUTERS);
    localparam int DEPTH    = ROUTERS * ROUTERS;
    localparam int AW       = $clog2(DEPTH);
    localparam int METRIC_W = dvrt_pkg::METRIC_W;

    logic [METRIC_W-1:0] metric_mem [DEPTH];
    logic [IW-1:0]       hop_mem    [DEPTH];
    logic [DEPTH-1:0]    valid_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;

    logic [METRIC_W-1:0] a_metric_reg;
    logic [IW-1:0]       a_hop_reg;
    logic                a_valid_reg;
    logic                a_diag_reg;
    logic [IW-1:0]       a_row_reg;
    logic [METRIC_W-1:0] b_metric_reg;
    logic [IW-1:0]       b_hop_reg;
    logic                b_valid_reg;
    logic                b_diag_reg;
    logic [IW-1:0]       b_row_reg;

    assign wr_addr = AW'(wr_row) * AW'(ROUTERS) + AW'(wr_col);
    assign a_addr  = AW'(a_row) * AW'(ROUTERS) + AW'(a_col);
    assign b_addr  = AW'(b_row) * AW'(ROUTERS) + AW'(b_col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            metric_mem[wr_addr] <= wr_metric;
            hop_mem[wr_addr]    <= wr_hop;
        end
        a_metric_reg <= metric_mem[a_addr];
        a_hop_reg    <= hop_mem[a_addr];
        a_valid_reg  <= valid_reg[a_addr];
        a_diag_reg   <= (a_row == a_col);
        a_row_reg    <= a_row;
        b_metric_reg <= metric_mem[b_addr];
        b_hop_reg    <= hop_mem[b_addr];
        b_valid_reg  <= valid_reg[b_addr];
        b_diag_reg   <= (b_row == b_col);
        b_row_reg    <= b_row;
    end

    // A clear drops every valid bit at once, which restores the reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        a_metric = a_valid_reg ? a_metric_reg : (a_diag_reg ? '0 : dvrt_pkg::UNREACH);
        a_hop    = a_valid_reg ? a_hop_reg    : (a_diag_reg ? a_row_reg : '0);
        b_metric = b_valid_reg ? b_metric_reg : (b_diag_reg ? '0 : dvrt_pkg::UNREACH);
        b_hop    = b_valid_reg ? b_hop_reg    : (b_diag_reg ? b_row_reg : '0);
    end

endmodule

`default_nettype wire

@@ design/distance_vector_route_table_core.sv @@
// Distance-vector route table core: command decode, round sequencer, output register.
// Depends on dvrt_pkg and dvrt_table.
//
// Usage: one command item enters on the input channel (in_valid / in_ready) and
// exactly one result item leaves on the output channel (out_valid / out_ready).
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// Set link and clear take effect at the accepting edge and go straight to the
// push state; a read first passes through the read-data state.
// An update round walks every (source, neighbor) pair, then every destination,
// through one adder and one comparator fed by the two table read ports: a
// diagonal pair is skipped, a pair with an unreachable link ends at the link
// check, and a pair with a reachable link visits each destination in turn.
// Results wait in the output register while the receiver stalls; the core goes
// back to idle only once the result has been loaded there, so a new command may
// be accepted while the previous result is still waiting to be taken.
// Reset (rst_n low) restores the table to its reset contents immediately and
// empties the output register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_table_core #(
    parameter int ROUTERS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    command,
    input  wire logic [1:0]                    router,
    input  wire logic [1:0]                    target,
    input  wire logic [dvrt_pkg::METRIC_W-1:0] link_metric,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [dvrt_pkg::METRIC_W-1:0] route_metric,
    output logic      [dvrt_pkg::HOP_W-1:0]    route_next_hop,
    output logic                               reachable,
    output logic      [dvrt_pkg::COUNT_W-1:0]  relax_count
);

    localparam int IW       = $clog2(ROUTERS);
    localparam int METRIC_W = dvrt_pkg::METRIC_W;
    localparam int HOP_W    = dvrt_pkg::HOP_W;
    localparam int COUNT_W  = dvrt_pkg::COUNT_W;
    localparam logic [IW-1:0] LAST = IW'(ROUTERS - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RD_DATA  = 3'd1;
    localparam logic [2:0] ST_LINK     = 3'd2;
    localparam logic [2:0] ST_LINK_CHK = 3'd3;
    localparam logic [2:0] ST_DST      = 3'd4;
    localparam logic [2:0] ST_CMP      = 3'd5;
    localparam logic [2:0] ST_PUSH     = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [IW-1:0]       src_reg, src_next;
    logic [IW-1:0]       nbr_reg, nbr_next;
    logic [IW-1:0]       dst_reg, dst_next;
    logic [METRIC_W-1:0] link_reg, link_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                rd_in_range_reg, rd_in_range_next;

    logic [METRIC_W-1:0] res_metric_reg, res_metric_next;
    logic [HOP_W-1:0]    res_hop_reg, res_hop_next;
    logic                res_reach_reg, res_reach_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;

    logic                out_valid_reg, out_valid_next;
    logic [METRIC_W-1:0] out_metric_reg;
    logic [HOP_W-1:0]    out_hop_reg;
    logic                out_reach_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_load;

    logic                clear;
    logic                wr_en;
    logic [IW-1:0]       wr_row, wr_col, wr_hop;
    logic [METRIC_W-1:0] wr_metric;
    logic [IW-1:0]       a_row, a_col, b_row, b_col;
    logic [METRIC_W-1:0] a_metric, b_metric;
    logic [IW-1:0]       a_hop, b_hop;

    logic                accept;
    logic                in_range;
    logic [METRIC_W:0]   cand;
    logic                advance_pair;

    dvrt_table #(
        .ROUTERS (ROUTERS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .wr_en     (wr_en),
        .wr_row    (wr_row),
        .wr_col    (wr_col),
        .wr_metric (wr_metric),
        .wr_hop    (wr_hop),
        .a_row     (a_row),
        .a_col     (a_col),
        .b_row     (b_row),
        .b_col     (b_col),
        .a_metric  (a_metric),
        .a_hop     (a_hop),
        .b_metric  (b_metric),
        .b_hop     (b_hop)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(router) < ROUTERS) && (32'(target) < ROUTERS);
    assign cand     = {1'b0, a_metric} + {1'b0, link_reg};

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        nbr_next       = nbr_reg;
        dst_next       = dst_reg;
        link_next      = link_reg;
        count_next     = count_reg;
        rd_in_range_next = rd_in_range_reg;
        res_metric_next = res_metric_reg;
        res_hop_next    = res_hop_reg;
        res_reach_next  = res_reach_reg;
        res_count_next  = res_count_reg;
        advance_pair   = 1'b0;
        clear          = 1'b0;
        wr_en          = 1'b0;
        wr_row         = nbr_reg;
        wr_col         = dst_reg;
        wr_hop         = src_reg;
        wr_metric      = cand[METRIC_W-1:0];
        a_row          = src_reg;
        a_col          = dst_reg;
        b_row          = nbr_reg;
        b_col          = dst_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                a_row = IW'(router);
                a_col = IW'(target);
                if (accept)
                begin
                    res_metric_next = '0;
                    res_hop_next    = '0;
                    res_reach_next  = 1'b0;
                    res_count_next  = '0;
                    rd_in_range_next = in_range;
                    unique case (command)
                        dvrt_pkg::CMD_SET:
                        begin
                            wr_en     = in_range && (router != target);
                            wr_row    = IW'(router);
                            wr_col    = IW'(target);
                            wr_hop    = IW'(target);
                            wr_metric = (link_metric > dvrt_pkg::UNREACH) ?
                                        dvrt_pkg::UNREACH : link_metric;
                            state_next = ST_PUSH;
                        end
                        dvrt_pkg::CMD_ROUND:
                        begin
                            src_next   = '0;
                            nbr_next   = '0;
                            count_next = '0;
                            state_next = ST_LINK;
                        end
                        dvrt_pkg::CMD_READ:
                        begin
                            state_next = ST_RD_DATA;
                        end
                        dvrt_pkg::CMD_CLEAR:
                        begin
                            clear      = 1'b1;
                            state_next = ST_PUSH;
                        end
                        default:
                        begin
                            state_next = ST_PUSH;
                        end
                    endcase
                end
            end
            ST_RD_DATA:
            begin
                res_metric_next = rd_in_range_reg ? a_metric : dvrt_pkg::UNREACH;
                res_hop_next    = rd_in_range_reg ? HOP_W'(a_hop) : '0;
                res_reach_next  = rd_in_range_reg && (a_metric < dvrt_pkg::UNREACH);
                state_next      = ST_PUSH;
            end
            ST_LINK:
            begin
                a_row = src_reg;
                a_col = nbr_reg;
                if (nbr_reg == src_reg)
                begin
                    advance_pair = 1'b1;
                end
                else
                begin
                    state_next = ST_LINK_CHK;
                end
            end
            ST_LINK_CHK:
            begin
                if (a_metric == dvrt_pkg::UNREACH)
                begin
                    advance_pair = 1'b1;
                end
                else
                begin
                    link_next  = a_metric;
                    dst_next   = '0;
                    state_next = ST_DST;
                end
            end
            ST_DST:
            begin
                // The source's own column is never relaxed.
                if (dst_reg == src_reg)
                begin
                    if (dst_reg == LAST)
                    begin
                        advance_pair = 1'b1;
                    end
                    else
                    begin
                        dst_next = dst_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (cand < {1'b0, b_metric})
                begin
                    wr_en = 1'b1;
                    if (count_reg != dvrt_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                if (dst_reg == LAST)
                begin
                    advance_pair = 1'b1;
                end
                else
                begin
                    dst_next   = dst_reg + 1'b1;
                    state_next = ST_DST;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance_pair)
        begin
            state_next = ST_LINK;
            if (nbr_reg == LAST)
            begin
                nbr_next = '0;
                if (src_reg == LAST)
                begin
                    res_count_next = count_next;
                    state_next     = ST_PUSH;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                end
            end
            else
            begin
                nbr_next = nbr_reg + 1'b1;
            end
        end
    end

    assign out_load = (state_reg == ST_PUSH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        nbr_reg        <= nbr_next;
        dst_reg        <= dst_next;
        link_reg       <= link_next;
        count_reg      <= count_next;
        rd_in_range_reg <= rd_in_range_next;
        res_metric_reg <= res_metric_next;
        res_hop_reg    <= res_hop_next;
        res_reach_reg  <= res_reach_next;
        res_count_reg  <= res_count_next;
        if (out_load)
        begin
            out_metric_reg <= res_metric_reg;
            out_hop_reg    <= res_hop_reg;
            out_reach_reg  <= res_reach_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign route_metric   = out_metric_reg;
    assign route_next_hop = out_hop_reg;
    assign reachable      = out_reach_reg;
    assign relax_count    = out_count_reg;

endmodule

`default_nettype wire

@@ design/dvrt_checker.sv @@
// Port-level checks for the distance-vector route table core, bound to the top level.
// Depends on dvrt_pkg and distance_vector_route_table_core.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [dvrt_pkg::METRIC_W-1:0] route_metric,
    input wire logic [dvrt_pkg::HOP_W-1:0]    route_next_hop,
    input wire logic                          reachable,
    input wire logic [dvrt_pkg::COUNT_W-1:0]  relax_count
);

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(route_metric)
        && $stable(route_next_hop) && $stable(reachable) && $stable(relax_count))
        else $error("result item changed while stalled");

    // One item at a time: the core is busy in the cycle after it accepts.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("core ready right after accepting an item");

    a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (route_metric <= dvrt_pkg::UNREACH)
        && (!reachable || (route_metric < dvrt_pkg::UNREACH)))
        else $error("metric out of range or reachable flag inconsistent");

    // Only a round reports relaxations, and a round reports no entry.
    a_round_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (relax_count != '0) |->
        (route_metric == '0) && (route_next_hop == '0) && !reachable)
        else $error("round result carries entry fields");

endmodule

bind distance_vector_route_table_core dvrt_checker u_dvrt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .route_metric   (route_metric),
    .route_next_hop (route_next_hop),
    .reachable      (reachable),
    .relax_count    (relax_count)
);

`default_nettype wire

@@ sim/tb_distance_vector_route_table_core.sv @@
// Testbench for distance_vector_route_table_core: directed and random command items
// checked against an in-bench route table predictor. Depends on dvrt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_distance_vector_route_table_core;

    localparam int NODES       = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 8;
    localparam int METRIC_W    = dvrt_pkg::METRIC_W;
    localparam int HOP_W       = dvrt_pkg::HOP_W;
    localparam int COUNT_W     = dvrt_pkg::COUNT_W;

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [HOP_W-1:0]    via;
        logic                reach;
        logic [COUNT_W-1:0]  relax;
    } route_result_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [1:0]          command     = dvrt_pkg::CMD_READ;
    logic [1:0]          router      = '0;
    logic [1:0]          target      = '0;
    logic [METRIC_W-1:0] link_metric = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [METRIC_W-1:0] route_metric;
    logic [HOP_W-1:0]    route_next_hop;
    logic                reachable;
    logic [COUNT_W-1:0]  relax_count;

    // Predicted table contents and the results still owed by the block.
    logic [METRIC_W-1:0] dist_tbl [NODES][NODES];
    logic [HOP_W-1:0]    via_tbl  [NODES][NODES];
    route_result_t       route_expect_q[$];

    bit idle_on;
    int items_sent;
    int fail_count  = 0;
    int cycle_count = 0;

    distance_vector_route_table_core #(
        .ROUTERS(NODES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .router         (router),
        .target         (target),
        .link_metric    (link_metric),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .route_metric   (route_metric),
        .route_next_hop (route_next_hop),
        .reachable      (reachable),
        .relax_count    (relax_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void reset_route_tables();
        for (int s = 0; s < NODES; s++)
        begin
            for (int d = 0; d < NODES; d++)
            begin
                dist_tbl[s][d] = (s == d) ? '0 : dvrt_pkg::UNREACH;
                via_tbl[s][d]  = (s == d) ? HOP_W'(s) : '0;
            end
        end
    endfunction

    // Applies one command to the predicted tables and returns the result it owes.
    function automatic route_result_t predict_route(dvrt_pkg::cmd_t c, logic [1:0] r,
                                                    logic [1:0] t, logic [METRIC_W-1:0] m);
        route_result_t res;
        int link;
        int cand;
        res = '0;
        case (c)
            dvrt_pkg::CMD_SET:
            begin
                if (r != t)
                begin
                    dist_tbl[r][t] = (m > dvrt_pkg::UNREACH) ? dvrt_pkg::UNREACH : m;
                    via_tbl[r][t]  = t;
                end
            end
            dvrt_pkg::CMD_ROUND:
            begin
                // Relaxation is in place: later pairs see the updates of earlier ones.
                for (int s = 0; s < NODES; s++)
                begin
                    for (int n = 0; n < NODES; n++)
                    begin
                        link = int'(dist_tbl[s][n]);
                        if (n != s && link != int'(dvrt_pkg::UNREACH))
                        begin
                            for (int d = 0; d < NODES; d++)
                            begin
                                cand = int'(dist_tbl[s][d]) + link;
                                if (d != s && cand < int'(dist_tbl[n][d]))
                                begin
                                    dist_tbl[n][d] = METRIC_W'(cand);
                                    via_tbl[n][d]  = HOP_W'(s);
                                    if (res.relax != dvrt_pkg::COUNT_MAX)
                                        res.relax = res.relax + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            dvrt_pkg::CMD_READ:
            begin
                res.metric = dist_tbl[r][t];
                res.via    = via_tbl[r][t];
                res.reach  = dist_tbl[r][t] < dvrt_pkg::UNREACH;
            end
            dvrt_pkg::CMD_CLEAR:
                reset_route_tables();
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Presents one command item and returns at the edge that accepts it. Valid is left
    // high so that a back-to-back item needs no second assignment in the same step.
    task automatic send_command(dvrt_pkg::cmd_t c, logic [1:0] r, logic [1:0] t,
                                logic [METRIC_W-1:0] m);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= c;
        router      <= r;
        target      <= t;
        link_metric <= m;
        do @(posedge clk); while (in_ready !== 1'b1);
        route_expect_q.push_back(predict_route(c, r, t, m));
        items_sent++;
    endtask

    initial
    begin : result_checker
        int stall;
        route_result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (route_expect_q.size() == 0)
                report_mismatch("item with nothing pending, metric", int'(route_metric), 0);
            else
            begin
                want = route_expect_q.pop_front();
                if (route_metric !== want.metric)
                    report_mismatch("route_metric", int'(route_metric), int'(want.metric));
                if (route_next_hop !== want.via)
                    report_mismatch("route_next_hop", int'(route_next_hop), int'(want.via));
                if (reachable !== want.reach)
                    report_mismatch("reachable", int'(reachable), int'(want.reach));
                if (relax_count !== want.relax)
                    report_mismatch("relax_count", int'(relax_count), int'(want.relax));
            end
        end
    end

    task automatic test_reset_contents();
        send_command(dvrt_pkg::CMD_READ, 2'd0, 2'd0, 5'd31);
        send_command(dvrt_pkg::CMD_READ, 2'd3, 2'd2, 5'd0);
    endtask

    // Zero metric, a metric past unreachable, a diagonal write and an unreachable link.
    task automatic test_link_extremes();
        send_command(dvrt_pkg::CMD_SET, 2'd0, 2'd1, 5'd0);
        send_command(dvrt_pkg::CMD_SET, 2'd1, 2'd2, 5'd31);
        send_command(dvrt_pkg::CMD_SET, 2'd2, 2'd2, 5'd5);
        send_command(dvrt_pkg::CMD_SET, 2'd0, 2'd3, dvrt_pkg::UNREACH);
        send_command(dvrt_pkg::CMD_READ, 2'd0, 2'd1, 5'd0);
        send_command(dvrt_pkg::CMD_READ, 2'd1, 2'd2, 5'd0);
        send_command(dvrt_pkg::CMD_READ, 2'd2, 2'd2, 5'd0);
        send_command(dvrt_pkg::CMD_READ, 2'd0, 2'd3, 5'd0);
    endtask

    task automatic test_round_relaxation();
        send_command(dvrt_pkg::CMD_CLEAR, 2'd1, 2'd2, 5'd7);
        send_command(dvrt_pkg::CMD_SET, 2'd0, 2'd1, 5'd3);
        send_command(dvrt_pkg::CMD_SET, 2'd1, 2'd2, 5'd4);
        send_command(dvrt_pkg::CMD_SET, 2'd2, 2'd3, 5'd1);
        send_command(dvrt_pkg::CMD_ROUND, 2'd0, 2'd0, 5'd0);
        send_command(dvrt_pkg::CMD_ROUND, 2'd3, 2'd3, 5'd31);
        send_command(dvrt_pkg::CMD_READ, 2'd2, 2'd0, 5'd0);
        send_command(dvrt_pkg::CMD_READ, 2'd3, 2'd0, 5'd0);
    endtask

    task automatic test_clear_table();
        send_command(dvrt_pkg::CMD_CLEAR, 2'd0, 2'd0, 5'd0);
        send_command(dvrt_pkg::CMD_READ, 2'd0, 2'd1, 5'd0);
        send_command(dvrt_pkg::CMD_ROUND, 2'd2, 2'd1, 5'd16);
    endtask

    // One topology: sometimes a clear, links with random metrics, a few rounds, reads, and a little noise.
    task automatic run_route_episode();
        int pick;
        logic [METRIC_W-1:0] m;
        if ($urandom_range(0, 3) == 0)
            send_command(dvrt_pkg::CMD_CLEAR, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), METRIC_W'($urandom_range(0, 31)));
        repeat ($urandom_range(1, 8))
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                m = METRIC_W'($urandom_range(1, 15));
            else if (pick == 7)
                m = '0;
            else if (pick == 8)
                m = dvrt_pkg::UNREACH;
            else
                m = METRIC_W'($urandom_range(17, 31));
            send_command(dvrt_pkg::CMD_SET, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), m);
        end
        repeat ($urandom_range(1, 3))
            send_command(dvrt_pkg::CMD_ROUND, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), METRIC_W'($urandom_range(0, 31)));
        repeat ($urandom_range(2, 6))
            send_command(dvrt_pkg::CMD_READ, 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), METRIC_W'($urandom_range(0, 31)));
        repeat ($urandom_range(0, 2))
            send_command(dvrt_pkg::cmd_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)), METRIC_W'($urandom_range(0, 31)));
    endtask

    task automatic test_random_back_to_back();
        idle_on = 1'b0;
        while (items_sent < 200)
            run_route_episode();
    endtask

    task automatic test_random_with_stalls();
        idle_on = 1'b1;
        while (items_sent < 720)
            run_route_episode();
    endtask

    initial
    begin
        idle_on    = 1'b1;
        items_sent = 0;
        reset_route_tables();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_link_extremes();
        test_round_relaxation();
        test_clear_table();
        test_random_back_to_back();
        test_random_with_stalls();

        in_valid <= 1'b0;
        wait (route_expect_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
